// File: src/bounded_sorted_priority_queue_top_macros.svh
// Assertion helpers shared by the queue RTL.
`ifndef BOUNDED_SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define BOUNDED_SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define BSPQ_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define BSPQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/bspq_pkg.sv
package bspq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int PRIO_W           = 16;
    localparam int PAYLOAD_W        = 32;
    localparam int COUNT_W          = 5;

    // Request operation codes
    localparam logic [1:0] MODE_ENQUEUE = 2'd0;
    localparam logic [1:0] MODE_DEQUEUE = 2'd1;
    localparam logic [1:0] MODE_CLEAR   = 2'd2;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic [PAYLOAD_W-1:0]     payload;
    } entry_t;

    // Per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_EVICT_INSERT,
        CELL_SHIFT,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctrl_t;

    // What a cell shows to its neighbors
    typedef struct packed {
        logic   valid;
        logic   ge;
        entry_t entry;
    } link_t;

    typedef struct packed {
        logic                     out_valid;
        logic signed [PRIO_W-1:0] out_priority;
        logic [PAYLOAD_W-1:0]     out_payload;
        logic                     evicted;
        logic                     error_code;
        logic [COUNT_W-1:0]       entry_count;
        logic                     is_empty;
        logic signed [PRIO_W-1:0] head_priority;
        logic [PAYLOAD_W-1:0]     head_payload;
    } rsp_t;

endpackage

// File: src/bspq_req_if.sv
interface bspq_req_if;
    import bspq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic signed [PRIO_W-1:0] item_priority;
    logic [PAYLOAD_W-1:0]     item_payload;

    modport source (output valid, mode, item_priority, item_payload, input ready);
    modport sink   (input valid, mode, item_priority, item_payload, output ready);
endinterface

// File: src/bspq_rsp_if.sv
interface bspq_rsp_if;
    import bspq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     out_valid;
    logic signed [PRIO_W-1:0] out_priority;
    logic [PAYLOAD_W-1:0]     out_payload;
    logic                     evicted;
    logic                     error_code;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic signed [PRIO_W-1:0] head_priority;
    logic [PAYLOAD_W-1:0]     head_payload;

    modport source (output valid, out_valid, out_priority, out_payload, evicted,
                    error_code, entry_count, is_empty, head_priority, head_payload,
                    input ready);
    modport sink   (input valid, out_valid, out_priority, out_payload, evicted,
                    error_code, entry_count, is_empty, head_priority, head_payload,
                    output ready);
endinterface

// File: src/bspq_cell.sv
module bspq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  bspq_pkg::cell_ctrl_t ctrl,
    input  bspq_pkg::link_t     left,
    input  bspq_pkg::link_t     right,
    output bspq_pkg::link_t     self_link,
    output bspq_pkg::entry_t    next_entry
);
    import bspq_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   ge;

    // Flag entries that stay ahead of the new request
    assign ge = valid_reg && (entry_reg.prio >= ctrl.new_entry.prio);

    assign self_link  = '{valid: valid_reg, ge: ge, entry: entry_reg};
    assign next_entry = entry_next;

    // Pick the new content from self, a neighbor or the request
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (!ge)
                begin
                    valid_next = valid_reg || left.valid || left.ge;
                    entry_next = left.ge ? ctrl.new_entry : left.entry;
                end
            end
            CELL_EVICT_INSERT:
            begin
                // Take the new entry at the last cell still ahead of it, or at
                // the head when nothing stays ahead
                if (right.ge)
                    entry_next = right.entry;
                else if (ge || (left.ge && !left.valid))
                    entry_next = ctrl.new_entry;
            end
            CELL_SHIFT:
            begin
                valid_next = right.valid;
                entry_next = right.entry;
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
                entry_next = entry_reg;
            end
        endcase
    end

    // Hold occupancy under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Advance stored entry
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end
endmodule

// File: src/bounded_sorted_priority_queue_top.sv
// Bounded priority queue built from a row of CAPACITY cells, head in cell 0,
// entries in descending priority, equal priorities served first in first out.
// Request channel (req): mode 0 enqueue, 1 dequeue head, 2 clear, 3 no-op,
// with item_priority and item_payload used by enqueue.
// Response channel (rsp): exactly one response per request, carrying the
// removed entry (dequeue, or eviction of the head on enqueue into a full
// queue), an error flag for dequeue on empty, and the count and head after
// the operation.
// The response is registered and becomes valid in the cycle after the request is accepted.
// Throughput: one request per cycle; every cell compares against the new
// priority and moves its entry to a neighbor in the same cycle, so no
// operation takes more than one pass through the row.
// A response waiting in the output register does not block the next request
// while rsp.ready is high; when the receiver stalls, req.ready drops and the
// held response stays unchanged until taken.
// Reset empties the queue and the output register; stored entries are not
// cleared, only their occupancy flags.
module bounded_sorted_priority_queue_top #(
    parameter int CAPACITY = bspq_pkg::DEFAULT_CAPACITY
) (
    input  logic            clk,
    input  logic            rst_n,
    bspq_req_if.sink        req,
    bspq_rsp_if.source      rsp
);
    import bspq_pkg::*;
    `include "bounded_sorted_priority_queue_top_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              res_valid_reg;
    rsp_t              res_reg;
    rsp_t              res_next;
    cell_ctrl_t        ctrl;
    link_t             links       [CAPACITY];
    link_t             left_links  [CAPACITY];
    link_t             right_links [CAPACITY];
    entry_t            next_entries[CAPACITY];
    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] order_ok;
    logic              accept;
    logic              full;
    logic              empty;
    logic [CNT_W+4:0]  count_wide;

    assign accept = req.valid && req.ready;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign req.ready = !res_valid_reg || rsp.ready;

    // Build the row of cells and their neighbor links
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            // Head sees a neighbor that is ahead of any request but holds nothing
            assign left_links[i] = '{valid: 1'b0, ge: 1'b1, entry: '0};
        end
        else
        begin : g_mid
            assign left_links[i] = links[i-1];
        end
        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_links[i] = '0;
            assign order_ok[i]    = 1'b1;
        end
        else
        begin : g_inner
            assign right_links[i] = links[i+1];
            assign order_ok[i]    = !links[i+1].valid ||
                                    (links[i].entry.prio >= links[i+1].entry.prio);
        end
        assign valid_vec[i] = links[i].valid;

        bspq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left       (left_links[i]),
            .right      (right_links[i]),
            .self_link  (links[i]),
            .next_entry (next_entries[i])
        );
    end

    // Decode the request into a cell command and the next count
    always_comb
    begin
        ctrl.new_entry = '{prio: req.item_priority, payload: req.item_payload};
        ctrl.op        = CELL_HOLD;
        count_next     = count_reg;
        if (accept)
        begin
            case (req.mode)
                MODE_ENQUEUE:
                begin
                    ctrl.op    = full ? CELL_EVICT_INSERT : CELL_INSERT;
                    count_next = full ? count_reg : count_reg + 1'b1;
                end
                MODE_DEQUEUE:
                begin
                    ctrl.op    = empty ? CELL_HOLD : CELL_SHIFT;
                    count_next = empty ? count_reg : count_reg - 1'b1;
                end
                MODE_CLEAR:
                begin
                    ctrl.op    = CELL_CLEAR;
                    count_next = '0;
                end
                default:
                begin
                    ctrl.op    = CELL_HOLD;
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Form the response from the old and the new head
    assign count_wide = (CNT_W + 5)'(count_next);

    always_comb
    begin
        res_next               = '0;
        res_next.entry_count   = count_wide[COUNT_W-1:0];
        res_next.is_empty      = (count_next == '0);
        if (count_next != '0)
        begin
            res_next.head_priority = next_entries[0].prio;
            res_next.head_payload  = next_entries[0].payload;
        end
        case (req.mode)
            MODE_ENQUEUE:
            begin
                if (full)
                begin
                    res_next.out_valid    = 1'b1;
                    res_next.evicted      = 1'b1;
                    res_next.out_priority = links[0].entry.prio;
                    res_next.out_payload  = links[0].entry.payload;
                end
            end
            MODE_DEQUEUE:
            begin
                if (empty)
                begin
                    res_next.error_code = 1'b1;
                end
                else
                begin
                    res_next.out_valid    = 1'b1;
                    res_next.out_priority = links[0].entry.prio;
                    res_next.out_payload  = links[0].entry.payload;
                end
            end
            default:
            begin
                res_next.out_valid = 1'b0;
            end
        endcase
    end

    // Hold count and response valid under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                res_valid_reg <= 1'b1;
            else if (rsp.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Load the response register on each accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    assign rsp.valid         = res_valid_reg;
    assign rsp.out_valid     = res_reg.out_valid;
    assign rsp.out_priority  = res_reg.out_priority;
    assign rsp.out_payload   = res_reg.out_payload;
    assign rsp.evicted       = res_reg.evicted;
    assign rsp.error_code    = res_reg.error_code;
    assign rsp.entry_count   = res_reg.entry_count;
    assign rsp.is_empty      = res_reg.is_empty;
    assign rsp.head_priority = res_reg.head_priority;
    assign rsp.head_payload  = res_reg.head_payload;

    `BSPQ_ASSERT_SAME(a_occupancy_packed, clk, rst_n, 1'b1, ((valid_vec + 1'b1) & valid_vec) == '0, "occupied cells are not packed at the head")
    `BSPQ_ASSERT_SAME(a_count_matches, clk, rst_n, 1'b1, $countones(valid_vec) == int'(count_reg), "fill count disagrees with cell occupancy")
    `BSPQ_ASSERT_SAME(a_sorted, clk, rst_n, 1'b1, &order_ok, "cells are not in descending priority order")
    `BSPQ_ASSERT_NEXT(a_empty_dequeue, clk, rst_n, accept && (req.mode == MODE_DEQUEUE) && empty, rsp.valid && rsp.error_code && !rsp.out_valid, "dequeue on empty not flagged")
endmodule

// File: tb/bounded_sorted_priority_queue_top_test.sv
`timescale 1ns / 1ps

module bounded_sorted_priority_queue_top_test;
    import bspq_pkg::*;

    localparam int         QUEUE_DEPTH      = DEFAULT_CAPACITY;
    localparam logic [1:0] MODE_NOP         = 2'd3;
    localparam int         RANDOM_REQUESTS  = 1425;
    localparam int         BURST_LEN        = 40;
    localparam int         MAX_WAIT         = 14;
    localparam int         SHOWN_MISMATCHES = 10;
    localparam int         DRAIN_CYCLES     = 5;
    localparam int         CYCLE_LIMIT      = 400000;

    // Shadow copy of the queue plus the responses it predicts
    class bspq_scoreboard;
        entry_t held[$];
        rsp_t   expected_rsps[$];
        int     mismatches;
        int     checked;
        int     peak_fill;
        int     evictions;
        int     empty_errors;
        int     op_count[4];

        function rsp_t predict_queue_op(logic [1:0] op, logic signed [PRIO_W-1:0] prio,
                                        logic [PAYLOAD_W-1:0] payload);
            rsp_t   r;
            entry_t fresh;
            int     pos;
            r = '0;
            fresh.prio = prio;
            fresh.payload = payload;
            case (op)
                MODE_ENQUEUE:
                begin
                    // Full queue: evict the head before inserting
                    if (held.size() >= QUEUE_DEPTH)
                    begin
                        r.out_valid = 1'b1;
                        r.evicted = 1'b1;
                        r.out_priority = held[0].prio;
                        r.out_payload = held[0].payload;
                        void'(held.pop_front());
                    end
                    // Insert after every entry of equal or higher priority
                    pos = 0;
                    while (pos < held.size() && $signed(held[pos].prio) >= $signed(prio))
                        pos++;
                    held.insert(pos, fresh);
                end
                MODE_DEQUEUE:
                begin
                    if (held.size() == 0)
                        r.error_code = 1'b1;
                    else
                    begin
                        r.out_valid = 1'b1;
                        r.out_priority = held[0].prio;
                        r.out_payload = held[0].payload;
                        void'(held.pop_front());
                    end
                end
                MODE_CLEAR:
                    held.delete();
                default:
                    ;
            endcase
            r.entry_count = COUNT_W'(held.size());
            r.is_empty = (held.size() == 0);
            if (held.size() > 0)
            begin
                r.head_priority = held[0].prio;
                r.head_payload = held[0].payload;
            end
            return r;
        endfunction

        function void note_request(logic [1:0] op, logic signed [PRIO_W-1:0] prio,
                                   logic [PAYLOAD_W-1:0] payload);
            rsp_t r;
            r = predict_queue_op(op, prio, payload);
            expected_rsps.push_back(r);
            op_count[op]++;
            if (r.evicted)
                evictions++;
            if (r.error_code)
                empty_errors++;
            if (held.size() > peak_fill)
                peak_fill = held.size();
        endfunction

        function string describe(rsp_t r);
            return $sformatf({"out_valid=%0b out_prio=%0d out_pay=%h evicted=%0b err=%0b ",
                              "count=%0d empty=%0b head_prio=%0d head_pay=%h"},
                             r.out_valid, r.out_priority, r.out_payload, r.evicted,
                             r.error_code, r.entry_count, r.is_empty, r.head_priority,
                             r.head_payload);
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp;
            bit   bad;
            if (expected_rsps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("[%0t] unexpected response: %s", $time, describe(got));
                return;
            end
            exp = expected_rsps.pop_front();
            checked++;
            bad = (got.out_valid !== exp.out_valid)
                || (got.out_priority !== exp.out_priority)
                || (got.out_payload !== exp.out_payload)
                || (got.evicted !== exp.evicted)
                || (got.error_code !== exp.error_code)
                || (got.entry_count !== exp.entry_count)
                || (got.is_empty !== exp.is_empty)
                || (got.head_priority !== exp.head_priority)
                || (got.head_payload !== exp.head_payload);
            if (bad)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                begin
                    $display("[%0t] response %0d mismatch", $time, checked);
                    $display("    expected: %s", describe(exp));
                    $display("    actual:   %s", describe(got));
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    bit   sender_calm;
    bit   receiver_calm;

    bspq_scoreboard sb;

    bspq_req_if req_ch();
    bspq_rsp_if rsp_ch();

    bounded_sorted_priority_queue_top #(
        .CAPACITY (QUEUE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Give up on a hung run
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d responses outstanding",
                 cycle_count, sb.expected_rsps.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic signed [PRIO_W-1:0] draw_priority();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return -16'sd32768;
        if (pick == 1)
            return 16'sd32767;
        // Narrow band so equal priorities collide often
        if (pick <= 4)
            return PRIO_W'($urandom_range(0, 7)) - 16'sd4;
        return PRIO_W'($urandom());
    endfunction

    // Send one request after a random gap; return once accepted
    task automatic send_request(logic [1:0] op, logic signed [PRIO_W-1:0] prio,
                                logic [PAYLOAD_W-1:0] payload);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_WAIT);
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.mode <= op;
        req_ch.item_priority <= prio;
        req_ch.item_payload <= payload;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(op, prio, payload);
    endtask

    task automatic run_directed();
        send_request(MODE_DEQUEUE, 16'sd0, 32'h0);
        send_request(MODE_NOP, 16'sd32767, 32'hFFFF_FFFF);
        send_request(MODE_ENQUEUE, 16'sd0, 32'h0);
        send_request(MODE_ENQUEUE, -16'sd32768, 32'hFFFF_FFFF);
        send_request(MODE_ENQUEUE, 16'sd32767, 32'hA5A5_5A5A);
        // Equal priorities must come out in arrival order
        send_request(MODE_ENQUEUE, 16'sd5, 32'h1);
        send_request(MODE_ENQUEUE, 16'sd5, 32'h2);
        send_request(MODE_ENQUEUE, 16'sd5, 32'h3);
        send_request(MODE_DEQUEUE, -16'sd1, 32'hFFFF_FFFF);
        // Fill to capacity
        for (int i = 0; i < 11; i++)
            send_request(MODE_ENQUEUE, PRIO_W'(i) - 16'sd5, 32'h100 + i);
        // Enqueue on full evicts the head whatever the new priority
        send_request(MODE_ENQUEUE, -16'sd32768, 32'hDEAD_0001);
        send_request(MODE_ENQUEUE, 16'sd32767, 32'hDEAD_0002);
        send_request(MODE_DEQUEUE, 16'sd0, 32'h0);
        send_request(MODE_CLEAR, 16'sd1234, 32'h5555_AAAA);
        send_request(MODE_DEQUEUE, 16'sd0, 32'h0);
    endtask

    task automatic run_random();
        int enqueue_pct;
        int pick;
        logic [1:0] op;
        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            // New burst: pick a fill-heavy, balanced or drain-heavy mix
            if (i % BURST_LEN == 0)
            begin
                case ($urandom_range(0, 2))
                    0: enqueue_pct = 30;
                    1: enqueue_pct = 55;
                    default: enqueue_pct = 85;
                endcase
                sender_calm = ($urandom_range(0, 3) == 0);
            end
            // Drop the request and hold off until the queue has answered everything
            if (i == RANDOM_REQUESTS / 2)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                while (sb.expected_rsps.size() != 0)
                    @(posedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
                op = MODE_NOP;
            else if (pick < 4)
                op = MODE_CLEAR;
            else if (pick < 4 + enqueue_pct)
                op = MODE_ENQUEUE;
            else
                op = MODE_DEQUEUE;
            send_request(op, draw_priority(), $urandom());
        end
    endtask

    // Response side: random stalls, check each accepted response
    initial
    begin
        int   stall;
        int   taken;
        rsp_t got;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            stall = receiver_calm ? 0 : $urandom_range(0, MAX_WAIT);
            @(negedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            got.out_valid = rsp_ch.out_valid;
            got.out_priority = rsp_ch.out_priority;
            got.out_payload = rsp_ch.out_payload;
            got.evicted = rsp_ch.evicted;
            got.error_code = rsp_ch.error_code;
            got.entry_count = rsp_ch.entry_count;
            got.is_empty = rsp_ch.is_empty;
            got.head_priority = rsp_ch.head_priority;
            got.head_payload = rsp_ch.head_payload;
            sb.check_response(got);
            taken++;
            if (taken % 90 == 0)
                receiver_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Main sequence
    initial
    begin
        sb = new();
        cycle_count = 0;
        sender_calm = 1'b0;
        receiver_calm = 1'b0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_NOP;
        req_ch.item_priority = '0;
        req_ch.item_payload = '0;
        rsp_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();
        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Drain, then watch for stray responses
        while (sb.expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d enqueues (%0d evicting), %0d dequeues (%0d on empty), %0d clears, %0d no-ops",
                 sb.op_count[MODE_ENQUEUE], sb.evictions, sb.op_count[MODE_DEQUEUE],
                 sb.empty_errors, sb.op_count[MODE_CLEAR], sb.op_count[MODE_NOP]);
        $display("Checked %0d responses, peak occupancy %0d of %0d, %0d mismatches",
                 sb.checked, sb.peak_fill, QUEUE_DEPTH, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_rsps.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: bounded_sorted_priority_queue_top.f
+incdir+src
src/bspq_pkg.sv
src/bspq_req_if.sv
src/bspq_rsp_if.sv
src/bspq_cell.sv
src/bounded_sorted_priority_queue_top.sv
tb/bounded_sorted_priority_queue_top_test.sv
